// ----- rtl/core/lph_pkg.sv -----
package lph_pkg;

  // Field widths of the request and response transfers.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned KEY_W = 50;
  localparam int unsigned VAL_W = 63;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned POS_W = 4;

  // The home slot comes from a residue unit. The key bits are summed as residues
  // of their weights in MOD_PARTS groups, the groups are added, and the sum is
  // brought below the table size by compare-and-subtract steps.
  localparam int unsigned MOD_PARTS   = 5;
  localparam int unsigned MOD_PART_W  = KEY_W / MOD_PARTS;
  localparam int unsigned MOD_RED_PER = 3;
  localparam int unsigned MOD_STEPS   = 4;
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_MOD   = 3'd2,
    S_HOME  = 3'd3,
    S_PRIME = 3'd4,
    S_PROBE = 3'd5
  } ctrl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lph_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] found_value;
  } lph_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lph_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic mod_start;
    logic mod_step;
    logic load_home;
    logic advance;
    logic count;
    logic commit;
  } lph_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic hit;
    logic probe_last;
    logic op_bad;
  } lph_sts_t;

endpackage

// ----- rtl/core/lph_dp.sv -----
module lph_dp import lph_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lph_cmd_t cmd_i,
  input  lph_req_t req_i,
  output lph_sts_t sts_o,
  output lph_rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  // The residue sum stays below 64 table sizes, so six reduction steps suffice.
  localparam int unsigned          SW          = AW + 2 * MOD_RED_PER;
  localparam logic [SW-1:0]        TS_SW       = SW'(TABLE_SIZE);
  localparam logic [AW-1:0]        LAST_SLOT   = AW'(TABLE_SIZE - 1);
  localparam logic [MOD_CNT_W-1:0] STEP_SUM    = MOD_CNT_W'(1);
  localparam logic [MOD_CNT_W-1:0] STEP_RED_HI = MOD_CNT_W'(2);
  localparam logic [MOD_CNT_W-1:0] STEP_RED_LO = MOD_CNT_W'(3);
  localparam int unsigned          RED_TOP_HI  = 2 * MOD_RED_PER - 1;
  localparam int unsigned          RED_TOP_LO  = MOD_RED_PER - 1;

  typedef logic [KEY_W-1:0][AW-1:0] res_tab_t;

  // Residue of each key bit weight, two to the power i modulo the table size.
  function automatic res_tab_t bit_res_tab();
    res_tab_t    tab;
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < KEY_W; i++) begin
      tab[i] = AW'(r);
      r = (2 * r) % TABLE_SIZE;
    end
    return tab;
  endfunction

  localparam res_tab_t BIT_RES = bit_res_tab();

  // Subtracts the table size shifted by top, top-1 and so on where it fits.
  function automatic logic [SW-1:0] reduce_step(input logic [SW-1:0] v,
                                                input int unsigned top);
    logic [SW-1:0] r;
    logic [SW-1:0] m;
    r = v;
    for (int unsigned k = 0; k < MOD_RED_PER; k++) begin
      m = TS_SW << (top - k);
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  lph_entry_t mem [TABLE_SIZE];

  lph_req_t                     req_q;
  logic [MOD_PARTS-1:0][SW-1:0] part_q, part_d;
  logic [SW-1:0]                sum_q, sum_d;
  logic [MOD_CNT_W-1:0]         dig_q;
  logic [AW-1:0]                slot_q, slot_next;
  logic [AW-1:0]                cmp_slot_q;
  logic [AW-1:0]                cnt_q;
  lph_entry_t                   rd_q;
  lph_rsp_t                     rsp_q, rsp_d;

  logic             is_ins, is_del, is_srch, op_bad, hit, do_write;
  logic [KEY_W-1:0] want;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  lph_entry_t       wr_data;

  // Group sums of the residues of the set key bits.
  always_comb begin
    for (int p = 0; p < MOD_PARTS; p++) begin
      part_d[p] = '0;
      for (int i = 0; i < MOD_PART_W; i++) begin
        if (req_q.key[p*MOD_PART_W + i]) begin
          part_d[p] = part_d[p] + SW'(BIT_RES[p*MOD_PART_W + i]);
        end
      end
    end
  end

  // Total of the groups, then a high and a low compare-and-subtract reduction.
  always_comb begin
    sum_d = sum_q;
    if (dig_q == STEP_SUM) begin
      sum_d = '0;
      for (int p = 0; p < MOD_PARTS; p++) begin
        sum_d = sum_d + part_q[p];
      end
    end else if (dig_q == STEP_RED_HI) begin
      sum_d = reduce_step(sum_q, RED_TOP_HI);
    end else if (dig_q == STEP_RED_LO) begin
      sum_d = reduce_step(sum_q, RED_TOP_LO);
    end
  end

  assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

  assign is_ins  = (req_q.op == OP_INSERT);
  assign is_del  = (req_q.op == OP_DELETE);
  assign is_srch = (req_q.op == OP_SEARCH);
  assign op_bad  = !(is_ins || is_del || is_srch);

  // Insert looks for an empty slot, delete and search for the key itself.
  assign want     = is_ins ? '0 : req_q.key;
  assign hit      = (rd_q.key == want);
  assign do_write = hit && (is_ins || is_del);

  assign wr_en   = cmd_i.clear_wr || (cmd_i.commit && do_write);
  assign wr_addr = cmd_i.clear_wr ? slot_q : cmp_slot_q;
  always_comb begin
    wr_data = '0;
    if (!cmd_i.clear_wr && is_ins) begin
      wr_data.key   = req_q.key;
      wr_data.value = req_q.value;
    end
  end

  always_comb begin
    rsp_d.status      = ST_MISS;
    rsp_d.position    = '0;
    rsp_d.found_value = '0;
    if (!op_bad) begin
      if (hit) begin
        rsp_d.status   = ST_OK;
        rsp_d.position = POS_W'(cmp_slot_q);
        if (is_srch) begin
          rsp_d.found_value = rd_q.value;
        end
      end else if (is_ins) begin
        rsp_d.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cmd_i.clear_wr || cmd_i.advance) begin
      slot_q <= slot_next;
    end else if (cmd_i.load_home) begin
      slot_q <= sum_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      req_q <= req_i;
      dig_q <= '0;
    end else if (cmd_i.mod_step) begin
      part_q <= part_d;
      sum_q  <= sum_d;
      dig_q  <= dig_q + 1'b1;
    end
    if (cmd_i.load_home) begin
      cnt_q <= '0;
    end else if (cmd_i.count) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.advance) begin
      cmp_slot_q <= slot_q;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // Single-port table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.advance) begin
      rd_q <= mem[slot_q];
    end
  end

  assign sts_o.clear_last = (slot_q == LAST_SLOT);
  assign sts_o.mod_last   = (dig_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign sts_o.hit        = hit;
  assign sts_o.probe_last = (cnt_q == LAST_SLOT);
  assign sts_o.op_bad     = op_bad;
  assign rsp_o            = rsp_q;

endmodule

// ----- rtl/core/lph_ctrl.sv -----
module lph_ctrl import lph_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  lph_sts_t sts_i,
  output lph_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_HOME;
        end
      end
      S_HOME: begin
        cmd_o.load_home = 1'b1;
        state_d         = S_PRIME;
      end
      S_PRIME: begin
        cmd_o.advance = 1'b1;
        state_d       = S_PROBE;
      end
      S_PROBE: begin
        if (sts_i.op_bad || sts_i.hit || sts_i.probe_last) begin
          if (out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          cmd_o.count   = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/linear_probe_hash_table_top.sv -----
// Open-addressing hash table with linear probing over TABLE_SIZE slots.
// Request channel (in_valid_i, in_ready_o, in_req_i) carries one operation per
// transfer: insert, delete or search on a nonzero key. Response channel
// (out_valid_o, out_ready_i, out_rsp_o) returns exactly one status, slot
// position and found value per request, in request order.
// The home slot comes from the residue unit (group sums of the key bit
// residues, their total, then a high and a low compare-and-subtract
// reduction), then S_HOME loads the home slot and S_PRIME primes the table
// read. The probe then compares one slot per cycle through the single table
// read port, over 1 to TABLE_SIZE slots. Requests are handled one at a time:
// a new request is taken only after the previous one has ended its probe
// and loaded its response.
// After reset a clearing pass writes every slot to empty while in_ready_o
// stays low.
// The response sits in an output register. A stalled receiver does not stop
// the next request from being taken and probed; only the final write-back
// and response load wait until the output register is free.
module linear_probe_hash_table_top import lph_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lph_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lph_rsp_t out_rsp_o
);

  // Commands and status between the sequencer and the table datapath.
  lph_cmd_t cmd;
  lph_sts_t sts;

  // The sequencer owns all handshakes and the response valid flag.
  lph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the request, the remainder unit, the slot table and
  // the response register.
  lph_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

// ----- rtl/core/lph_chk.sv -----
module lph_chk import lph_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input lph_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input lph_rsp_t out_rsp_o
);

  // A response waiting on the receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // One request at a time: the request side closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_MISS ||
                     out_rsp_o.status == ST_FULL))
    else $error("undefined status code");

  // A miss or a full table reports neither a slot nor a value.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |->
      out_rsp_o.position == '0 && out_rsp_o.found_value == '0)
    else $error("failed operation reports a slot or value");

endmodule

bind linear_probe_hash_table_top lph_chk u_lph_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
